// ----- rtl/lfu_bc_pkg.sv -----
// Shared types and constants for the LFU block cache lookup core.
// Holds the controller/datapath command and status structs and fixed field widths.
// No dependencies.
package lfu_bc_pkg;

  // Fixed field widths
  localparam int unsigned TagW  = 32;
  localparam int unsigned CfgW  = 5;
  localparam int unsigned SlotW = 4;

  // Reset value of the entries-in-use register
  localparam logic [CfgW-1:0] CfgReset = 5'd16;

  // Commands from controller to datapath
  typedef struct packed {
    logic start;   // latch request, clear search trackers
    logic scan;    // read entry at scan index, advance index
    logic commit;  // write back chosen entry, load result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_last;  // scan index points at the last entry in use
  } sts_t;

endpackage

// ----- rtl/lfu_bc_ctrl.sv -----
// Controller state machine for the LFU block cache lookup core.
// Sequences scan, update and result hand-off; depends on lfu_bc_pkg.
module lfu_bc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lfu_bc_pkg::sts_t  sts_i,
  output lfu_bc_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_TAIL = 4'b0100,
    S_UPD  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    out_valid_d  = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        // last read is evaluated in the datapath this cycle
        state_d = S_UPD;
      end
      S_UPD: begin
        // hold the decision until the result register is free
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/lfu_bc_dp.sv -----
// Datapath for the LFU block cache lookup core: tag and count memories,
// valid flags, search trackers, config register and result register.
// Depends on lfu_bc_pkg.
module lfu_bc_dp #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lfu_bc_pkg::cmd_t              cmd_i,
  output lfu_bc_pkg::sts_t              sts_o,
  input  logic                          cfg_we_i,
  input  logic [lfu_bc_pkg::CfgW-1:0]   cfg_data_i,
  input  logic [lfu_bc_pkg::TagW-1:0]   block_index_i,
  output logic [lfu_bc_pkg::SlotW-1:0]  slot_index_o,
  output logic                          hit_o,
  output logic                          replaced_o,
  output logic [lfu_bc_pkg::TagW-1:0]   old_block_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};

  // Config register and active range
  logic [lfu_bc_pkg::CfgW-1:0] cfg_q;
  logic [31:0]                 n_ext, last_ext;
  logic [IdxW-1:0]             last_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= lfu_bc_pkg::CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // zero counts as one, anything above the array size clamps to it
  always_comb begin
    if (cfg_q == '0) begin
      n_ext = 32'd1;
    end else if (32'(cfg_q) > 32'(ENTRIES)) begin
      n_ext = 32'(ENTRIES);
    end else begin
      n_ext = 32'(cfg_q);
    end
    last_ext = n_ext - 32'd1;
  end
  assign last_idx = last_ext[IdxW-1:0];

  // Scan index and read pipeline
  logic [IdxW-1:0] scan_idx_q;
  logic [IdxW-1:0] ev_idx_q;
  logic            ev_vld_q;

  assign sts_o.scan_last = (scan_idx_q == last_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      ev_idx_q   <= '0;
      ev_vld_q   <= 1'b0;
    end else begin
      ev_vld_q <= cmd_i.scan;
      if (cmd_i.start) begin
        scan_idx_q <= '0;
      end else if (cmd_i.scan) begin
        scan_idx_q <= scan_idx_q + IdxW'(1);
        ev_idx_q   <= scan_idx_q;
      end
    end
  end

  // Valid flags
  logic [ENTRIES-1:0] valid_q;
  logic               ev_valid;
  assign ev_valid = valid_q[ev_idx_q];

  // Commit selection
  logic [IdxW-1:0]            slot_sel;
  logic [COUNT_BITS-1:0]      cnt_sel, cnt_new;
  logic                       repl_sel;
  logic [lfu_bc_pkg::TagW-1:0] old_sel;
  logic [31:0]                slot_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.commit) begin
      valid_q[slot_sel] <= 1'b1;
    end
  end

  // Tag and count memories
  logic [lfu_bc_pkg::TagW-1:0] tag_mem [ENTRIES];
  logic [COUNT_BITS-1:0]       cnt_mem [ENTRIES];
  logic [lfu_bc_pkg::TagW-1:0] tag_rd_q;
  logic [COUNT_BITS-1:0]       cnt_rd_q;
  logic [lfu_bc_pkg::TagW-1:0] blk_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      tag_rd_q <= tag_mem[scan_idx_q];
      cnt_rd_q <= cnt_mem[scan_idx_q];
    end
    // on a hit the stored tag already equals the request
    if (cmd_i.commit) begin
      tag_mem[slot_sel] <= blk_q;
      cnt_mem[slot_sel] <= cnt_new;
    end
  end

  // Search trackers
  logic                        hit_q, inv_q;
  logic [IdxW-1:0]             hit_idx_q, inv_idx_q, min_idx_q;
  logic [COUNT_BITS-1:0]       hit_cnt_q, min_cnt_q;
  logic [lfu_bc_pkg::TagW-1:0] min_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      inv_q <= 1'b0;
    end else if (cmd_i.start) begin
      hit_q <= 1'b0;
      inv_q <= 1'b0;
    end else if (ev_vld_q) begin
      if (ev_valid && (tag_rd_q == blk_q) && !hit_q) begin
        hit_q <= 1'b1;
      end
      if (!ev_valid && !inv_q) begin
        inv_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      blk_q <= block_index_i;
    end
    if (ev_vld_q) begin
      if (ev_valid && (tag_rd_q == blk_q) && !hit_q) begin
        hit_idx_q <= ev_idx_q;
        hit_cnt_q <= cnt_rd_q;
      end
      if (!ev_valid && !inv_q) begin
        inv_idx_q <= ev_idx_q;
      end
      // strict compare keeps the lowest index on ties
      if ((ev_idx_q == '0) || (cnt_rd_q < min_cnt_q)) begin
        min_idx_q <= ev_idx_q;
        min_cnt_q <= cnt_rd_q;
        min_tag_q <= tag_rd_q;
      end
    end
  end

  // Pick the entry: hit, else first free, else least used
  always_comb begin
    repl_sel = 1'b0;
    old_sel  = '0;
    if (hit_q) begin
      slot_sel = hit_idx_q;
      cnt_sel  = hit_cnt_q;
    end else if (inv_q) begin
      slot_sel = inv_idx_q;
      cnt_sel  = '0;
    end else begin
      slot_sel = min_idx_q;
      cnt_sel  = min_cnt_q;
      repl_sel = 1'b1;
      old_sel  = min_tag_q;
    end
    cnt_new  = (cnt_sel == CntMax) ? cnt_sel : cnt_sel + COUNT_BITS'(1);
    slot_ext = 32'(slot_sel);
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      slot_index_o <= slot_ext[lfu_bc_pkg::SlotW-1:0];
      hit_o        <= hit_q;
      replaced_o   <= repl_sel;
      old_block_o  <= old_sel;
    end
  end

endmodule

// ----- rtl/lfu_block_cache_lookup_core.sv -----
// Top level of the LFU block cache lookup core.
// Joins lfu_bc_ctrl and lfu_bc_dp; depends on lfu_bc_pkg.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o   block_index_i
// out      output     out_valid_o/out_ready_i slot_index_o, hit_o, replaced_o, old_block_o
// cfg      input      cfg_valid_i/cfg_ready_o cfg_data_i (entries in use)
//
// The tag/count memory is read one entry per cycle over the n entries in use; the
// result register is loaded at the update step, and the next request is taken once
// the controller is back in idle.
// Reset clears valid flags, so no clearing pass is needed.
// A new request is taken while the previous result waits; its update stalls
// until the result register is free. Config writes are always taken.
module lfu_block_cache_lookup_core #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lfu_bc_pkg::TagW-1:0]   block_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lfu_bc_pkg::SlotW-1:0]  slot_index_o,
  output logic                          hit_o,
  output logic                          replaced_o,
  output logic [lfu_bc_pkg::TagW-1:0]   old_block_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lfu_bc_pkg::CfgW-1:0]   cfg_data_i
);

  lfu_bc_pkg::cmd_t cmd;
  lfu_bc_pkg::sts_t sts;

  // config writes are always taken; the user must issue them with no lookup in flight, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  lfu_bc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lfu_bc_dp #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .block_index_i (block_index_i),
    .slot_index_o  (slot_index_o),
    .hit_o         (hit_o),
    .replaced_o    (replaced_o),
    .old_block_o   (old_block_o)
  );

endmodule
